// ===== hdl/kptq_pkg.sv =====
// Package for the keyed priority task queue.
// Holds operation and status codes, stream field layout and the cell command type.
// No dependencies.
package kptq_pkg;

	localparam int CAPACITY_DEF  = 64;
	localparam int KEY_BITS_DEF  = 16;
	localparam int PRIO_BITS_DEF = 32;

	// operation codes
	localparam logic [1:0] OP_ADD    = 2'd0;
	localparam logic [1:0] OP_EDIT   = 2'd1;
	localparam logic [1:0] OP_REMOVE = 2'd2;
	localparam logic [1:0] OP_EXEC   = 2'd3;

	// status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_EMPTY   = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;
	localparam logic [1:0] ST_UNKNOWN = 2'd3;

	// field widths and slave-side tdata layout
	localparam int OP_W     = 2;
	localparam int OWNER_W  = 16;
	localparam int TKEY_W   = 16;
	localparam int PRIO_W   = 32;
	localparam int STATUS_W = 2;

	localparam int OP_LSB    = 0;
	localparam int OWNER_LSB = OP_LSB + OP_W;
	localparam int TKEY_LSB  = OWNER_LSB + OWNER_W;
	localparam int PRIO_LSB  = TKEY_LSB + TKEY_W;
	localparam int S_USED_W  = PRIO_LSB + PRIO_W;
	localparam int S_TDATA_W = ((S_USED_W + 7) / 8) * 8;

	localparam int STATUS_LSB = 0;
	localparam int SERVED_LSB = STATUS_LSB + STATUS_W;
	localparam int M_USED_W   = SERVED_LSB + OWNER_W;
	localparam int M_TDATA_W  = ((M_USED_W + 7) / 8) * 8;

	// command broadcast to every cell in the update cycle
	typedef struct packed {
		logic rem;  // take out the entry matching the removal pair, close the gap
		logic ins;  // insert the new entry in sorted position
	} cell_cmd_t;

endpackage

// ===== hdl/keyed_priority_task_queue.sv =====
// Top level of the keyed priority task queue: stream ports, lookup and command control.
// Instantiates a row of kptq_cell kept sorted by (priority, key), highest first.
// Depends on kptq_pkg and kptq_cell.
//
// Each slave transaction carries one operation (add, edit, remove, execute top) and
// yields exactly one master transaction with a status and, for a successful execute,
// the served owner. Each operation has a lookup and an update: in the accept cycle
// every cell compares its key against the incoming key and the hit entry (the top
// entry for an execute) is captured; in the update the chain shifts once (gap
// closing, sorted insertion, or both for an edit or an add of a present key). A new
// transaction is taken only after the update of the previous one, as lookup and
// update share the cell row. The update waits while an earlier result is still
// held on the master side. Cell 0 always holds the top entry; valid entries are
// packed from cell 0 upward, so the store is full when the last cell is valid.
module keyed_priority_task_queue
	import kptq_pkg::*;
#(
	parameter int CAPACITY  = CAPACITY_DEF,
	parameter int KEY_BITS  = KEY_BITS_DEF,
	parameter int PRIO_BITS = PRIO_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,   // op, owner_id, task_key, prio_value, zero pad
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata    // status, served_owner, zero pad
);

	logic [OP_W-1:0]      in_op;
	logic [OWNER_W-1:0]   in_owner;
	logic [KEY_BITS-1:0]  in_key;
	logic [PRIO_BITS-1:0] in_prio;
	logic                 accept;
	logic                 apply;

	logic                 busy_q;
	logic [OP_W-1:0]      op_s1;
	logic [OWNER_W-1:0]   owner_s1;
	logic [KEY_BITS-1:0]  key_s1;
	logic [PRIO_BITS-1:0] prio_s1;
	logic                 found_s1;
	logic [OWNER_W-1:0]   fown_s1;
	logic [KEY_BITS-1:0]  fkey_s1;
	logic [PRIO_BITS-1:0] fprio_s1;
	logic                 full_s1;

	logic                 m_valid_q;
	logic [STATUS_W-1:0]  status_q;
	logic [OWNER_W-1:0]   served_q;

	cell_cmd_t            cmd;
	logic [STATUS_W-1:0]  status_n;
	logic [OWNER_W-1:0]   served_n;
	logic [OWNER_W-1:0]   ins_owner;

	logic                 c_valid   [CAPACITY];
	logic [OWNER_W-1:0]   c_owner   [CAPACITY];
	logic [KEY_BITS-1:0]  c_key     [CAPACITY];
	logic [PRIO_BITS-1:0] c_prio    [CAPACITY];
	logic                 c_match   [CAPACITY];
	logic                 c_pvalid  [CAPACITY];
	logic [OWNER_W-1:0]   c_powner  [CAPACITY];
	logic [KEY_BITS-1:0]  c_pkey    [CAPACITY];
	logic [PRIO_BITS-1:0] c_pprio   [CAPACITY];
	logic                 c_pgt     [CAPACITY];

	logic                 hit;
	logic [OWNER_W-1:0]   hit_owner;
	logic [PRIO_BITS-1:0] hit_prio;

	assign in_op    = s_tdata[OP_LSB +: OP_W];
	assign in_owner = s_tdata[OWNER_LSB +: OWNER_W];
	assign in_key   = KEY_BITS'(s_tdata[TKEY_LSB +: TKEY_W]);
	assign in_prio  = PRIO_BITS'(s_tdata[PRIO_LSB +: PRIO_W]);

	assign s_tready = !busy_q;
	assign accept   = s_tvalid && !busy_q;
	assign apply    = busy_q && (!m_valid_q || m_tready);

	// keys are unique, so at most one cell hits
	always_comb begin
		hit       = 1'b0;
		hit_owner = '0;
		hit_prio  = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			hit       = hit | c_match[i];
			hit_owner = hit_owner | (c_owner[i] & {OWNER_W{c_match[i]}});
			hit_prio  = hit_prio | (c_prio[i] & {PRIO_BITS{c_match[i]}});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (accept) begin
			busy_q <= 1'b1;
		end else if (apply) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1    <= in_op;
			owner_s1 <= in_owner;
			key_s1   <= in_key;
			prio_s1  <= in_prio;
			full_s1  <= c_valid[CAPACITY-1];
			if (in_op == OP_EXEC) begin
				found_s1 <= c_valid[0];
				fown_s1  <= c_owner[0];
				fkey_s1  <= c_key[0];
				fprio_s1 <= c_prio[0];
			end else begin
				found_s1 <= hit;
				fown_s1  <= hit_owner;
				fkey_s1  <= in_key;
				fprio_s1 <= hit_prio;
			end
		end
	end

	always_comb begin
		cmd       = '0;
		status_n  = ST_OK;
		served_n  = '0;
		ins_owner = owner_s1;
		unique case (op_s1)
			OP_ADD: begin
				if (found_s1) begin
					cmd.rem = 1'b1;
					cmd.ins = 1'b1;
				end else if (full_s1) begin
					status_n = ST_FULL;
				end else begin
					cmd.ins = 1'b1;
				end
			end
			OP_EDIT: begin
				ins_owner = fown_s1;
				if (found_s1) begin
					cmd.rem = 1'b1;
					cmd.ins = 1'b1;
				end else begin
					status_n = ST_UNKNOWN;
				end
			end
			OP_REMOVE: begin
				if (found_s1) begin
					cmd.rem = 1'b1;
				end else begin
					status_n = ST_UNKNOWN;
				end
			end
			OP_EXEC: begin
				if (found_s1) begin
					cmd.rem  = 1'b1;
					served_n = fown_s1;
				end else begin
					status_n = ST_EMPTY;
				end
			end
			default: begin
				status_n = ST_OK;
			end
		endcase
		if (!apply) begin
			cmd = '0;
		end
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic                 r_valid;
		logic [OWNER_W-1:0]   r_owner;
		logic [KEY_BITS-1:0]  r_key;
		logic [PRIO_BITS-1:0] r_prio;
		logic                 l_valid;
		logic [OWNER_W-1:0]   l_owner;
		logic [KEY_BITS-1:0]  l_key;
		logic [PRIO_BITS-1:0] l_prio;
		logic                 l_gt;

		if (i == CAPACITY - 1) begin : g_last
			assign r_valid = 1'b0;
			assign r_owner = '0;
			assign r_key   = '0;
			assign r_prio  = '0;
		end else begin : g_mid
			assign r_valid = c_valid[i+1];
			assign r_owner = c_owner[i+1];
			assign r_key   = c_key[i+1];
			assign r_prio  = c_prio[i+1];
		end

		if (i == 0) begin : g_first
			assign l_valid = 1'b0;
			assign l_owner = '0;
			assign l_key   = '0;
			assign l_prio  = '0;
			assign l_gt    = 1'b0;
		end else begin : g_rest
			assign l_valid = c_pvalid[i-1];
			assign l_owner = c_powner[i-1];
			assign l_key   = c_pkey[i-1];
			assign l_prio  = c_pprio[i-1];
			assign l_gt    = c_pgt[i-1];
		end

		kptq_cell #(
			.KEY_BITS  (KEY_BITS),
			.PRIO_BITS (PRIO_BITS)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cmd       (cmd),
			.probe_key (in_key),
			.rem_key   (fkey_s1),
			.rem_prio  (fprio_s1),
			.new_owner (ins_owner),
			.new_key   (key_s1),
			.new_prio  (prio_s1),
			.r_valid   (r_valid),
			.r_owner   (r_owner),
			.r_key     (r_key),
			.r_prio    (r_prio),
			.l_valid   (l_valid),
			.l_owner   (l_owner),
			.l_key     (l_key),
			.l_prio    (l_prio),
			.l_gt      (l_gt),
			.valid     (c_valid[i]),
			.owner     (c_owner[i]),
			.key       (c_key[i]),
			.prio      (c_prio[i]),
			.match     (c_match[i]),
			.p_valid   (c_pvalid[i]),
			.p_owner   (c_powner[i]),
			.p_key     (c_pkey[i]),
			.p_prio    (c_pprio[i]),
			.p_gt      (c_pgt[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (apply) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (apply) begin
			status_q <= status_n;
			served_q <= served_n;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = M_TDATA_W'({served_q, status_q});

endmodule

// ===== hdl/kptq_cell.sv =====
// One cell of the sorted entry chain of the keyed priority task queue.
// Holds one entry; shifts left on removal and right on insertion using neighbor data.
// Depends on kptq_pkg.
module kptq_cell
	import kptq_pkg::*;
#(
	parameter int KEY_BITS  = KEY_BITS_DEF,
	parameter int PRIO_BITS = PRIO_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cell_cmd_t            cmd,
	input  logic [KEY_BITS-1:0]  probe_key,
	input  logic [KEY_BITS-1:0]  rem_key,
	input  logic [PRIO_BITS-1:0] rem_prio,
	input  logic [OWNER_W-1:0]   new_owner,
	input  logic [KEY_BITS-1:0]  new_key,
	input  logic [PRIO_BITS-1:0] new_prio,
	// right neighbor, current entry
	input  logic                 r_valid,
	input  logic [OWNER_W-1:0]   r_owner,
	input  logic [KEY_BITS-1:0]  r_key,
	input  logic [PRIO_BITS-1:0] r_prio,
	// left neighbor, entry after removal and its insert compare
	input  logic                 l_valid,
	input  logic [OWNER_W-1:0]   l_owner,
	input  logic [KEY_BITS-1:0]  l_key,
	input  logic [PRIO_BITS-1:0] l_prio,
	input  logic                 l_gt,
	// own current entry
	output logic                 valid,
	output logic [OWNER_W-1:0]   owner,
	output logic [KEY_BITS-1:0]  key,
	output logic [PRIO_BITS-1:0] prio,
	output logic                 match,
	// own entry after removal and insert compare
	output logic                 p_valid,
	output logic [OWNER_W-1:0]   p_owner,
	output logic [KEY_BITS-1:0]  p_key,
	output logic [PRIO_BITS-1:0] p_prio,
	output logic                 p_gt
);

	logic                 valid_q;
	logic [OWNER_W-1:0]   owner_q;
	logic [KEY_BITS-1:0]  key_q;
	logic [PRIO_BITS-1:0] prio_q;

	logic                 shift_left;
	logic                 n_valid;
	logic [OWNER_W-1:0]   n_owner;
	logic [KEY_BITS-1:0]  n_key;
	logic [PRIO_BITS-1:0] n_prio;

	assign valid = valid_q;
	assign owner = owner_q;
	assign key   = key_q;
	assign prio  = prio_q;
	assign match = valid_q && (key_q == probe_key);

	// chain is sorted high to low, so every cell at or below the removed pair moves up
	assign shift_left = cmd.rem && (!valid_q || ({prio_q, key_q} <= {rem_prio, rem_key}));

	always_comb begin
		if (shift_left) begin
			p_valid = r_valid;
			p_owner = r_owner;
			p_key   = r_key;
			p_prio  = r_prio;
		end else begin
			p_valid = valid_q;
			p_owner = owner_q;
			p_key   = key_q;
			p_prio  = prio_q;
		end
	end

	assign p_gt = !p_valid || ({new_prio, new_key} > {p_prio, p_key});

	always_comb begin
		n_valid = p_valid;
		n_owner = p_owner;
		n_key   = p_key;
		n_prio  = p_prio;
		if (cmd.ins && p_gt) begin
			if (l_gt) begin
				n_valid = l_valid;
				n_owner = l_owner;
				n_key   = l_key;
				n_prio  = l_prio;
			end else begin
				n_valid = 1'b1;
				n_owner = new_owner;
				n_key   = new_key;
				n_prio  = new_prio;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= n_valid;
		end
	end

	always_ff @(posedge clk) begin
		owner_q <= n_owner;
		key_q   <= n_key;
		prio_q  <= n_prio;
	end

endmodule

// ===== hdl/kptq_checker.sv =====
// Port-level checks for the keyed priority task queue, bound to the top level.
// Watches the stream handshakes and the result fields over time.
// Depends on kptq_pkg and keyed_priority_task_queue.
module kptq_checker
	import kptq_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_tvalid,
	input logic                 s_tready,
	input logic                 m_tvalid,
	input logic                 m_tready,
	input logic [M_TDATA_W-1:0] m_tdata
);

	logic [STATUS_W-1:0] status;
	logic [OWNER_W-1:0]  served;

	assign status = m_tdata[STATUS_LSB +: STATUS_W];
	assign served = m_tdata[SERVED_LSB +: OWNER_W];

	// one operation in flight: no second transaction right after an accept
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("slave accepted back to back");

	// when the update slot is open right after an accept, the result appears in the cycle after
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) ##1 (!m_tvalid || m_tready) |=> m_tvalid)
		else $error("result missing after operation");

	// a failed operation serves no owner
	a_fail_no_owner: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (status != ST_OK) |-> served == '0)
		else $error("owner reported on failed operation");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");

endmodule

bind keyed_priority_task_queue kptq_checker u_kptq_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
